// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the core RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, skipped while reset is active.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/hldf_pkg.sv -----
// ----------------------------------------------------------------------------
// hldf_pkg
// Types, constants and tables of the line segment duplicate filter.
// ----------------------------------------------------------------------------
package hldf_pkg;

	localparam int MAX_SEG      = 64;
	localparam int SEG_AW       = $clog2(MAX_SEG);
	localparam int CNT_W        = SEG_AW + 1;
	localparam int COORD_W      = 12;
	localparam int CORDIC_STEPS = 20;
	localparam int DIV_STEPS    = 58;
	localparam int SQRT_STEPS   = 18;
	localparam int SEG_W        = 4 * COORD_W;
	localparam int POLAR_W      = 34;

	localparam logic signed [16:0] PI_Q      = 17'sd25736;
	localparam logic signed [16:0] HALF_PI_Q = 17'sd12868;
	localparam logic signed [23:0] HALF_PI_Z = 24'sd1647099;

	localparam logic [2:0] CFG_ANGLE_LIMIT  = 3'd0;
	localparam logic [2:0] CFG_ANGLE_SIM    = 3'd1;
	localparam logic [2:0] CFG_RHO_SIM      = 3'd2;
	localparam logic [2:0] CFG_VERT_TOL     = 3'd3;

	localparam logic [14:0] RST_ANGLE_LIMIT = 15'd5147;
	localparam logic [14:0] RST_ANGLE_SIM   = 15'd858;
	localparam logic [16:0] RST_RHO_SIM     = 17'd128;
	localparam logic [13:0] RST_VERT_TOL    = 14'd0;

	typedef struct packed {
		logic [14:0] angle_limit;
		logic [14:0] angle_similarity;
		logic [16:0] rho_similarity;
		logic [13:0] vertical_tolerance;
	} hldf_cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic signed [17:0] rho;
		logic signed [15:0] theta;
		logic               final_segment;
	} hldf_item_t;

	function automatic logic signed [23:0] atan_entry(input logic [4:0] idx);
		logic signed [23:0] v;
		case (idx)
			5'd0:  v = 24'sd823550;
			5'd1:  v = 24'sd486170;
			5'd2:  v = 24'sd256879;
			5'd3:  v = 24'sd130396;
			5'd4:  v = 24'sd65451;
			5'd5:  v = 24'sd32757;
			5'd6:  v = 24'sd16383;
			5'd7:  v = 24'sd8192;
			5'd8:  v = 24'sd4096;
			5'd9:  v = 24'sd2048;
			5'd10: v = 24'sd1024;
			5'd11: v = 24'sd512;
			5'd12: v = 24'sd256;
			5'd13: v = 24'sd128;
			5'd14: v = 24'sd64;
			5'd15: v = 24'sd32;
			5'd16: v = 24'sd16;
			5'd17: v = 24'sd8;
			5'd18: v = 24'sd4;
			5'd19: v = 24'sd2;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/hldf_ram.sv -----
// ----------------------------------------------------------------------------
// hldf_ram
// Generic single write port memory with one registered read port.
// ----------------------------------------------------------------------------
module hldf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/hldf_front.sv -----
// ----------------------------------------------------------------------------
// hldf_front
// Accepts segments and converts each to polar form with a CORDIC angle unit,
// a bit-serial divider and a bit-pair square root.
// ----------------------------------------------------------------------------
module hldf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hldf_pkg::COORD_W-1:0] x_start,
	input  logic [hldf_pkg::COORD_W-1:0] y_start,
	input  logic [hldf_pkg::COORD_W-1:0] x_end,
	input  logic [hldf_pkg::COORD_W-1:0] y_end,
	input  logic                        final_segment,
	output logic                        push,
	input  logic                        full,
	output hldf_pkg::hldf_item_t        item
);

	typedef enum logic [3:0] {
		S_IDLE, S_C0, S_C1, S_DX, S_DY, S_AA, S_DIV, S_SQRT, S_FIN, S_PUSH
	} fstate_t;

	fstate_t state_q;
	logic [11:0] x1_q, y1_q, x2_q, y2_q;
	logic        fin_q;
	logic [23:0] p_q, a_q, sq_q;
	logic [24:0] l2_q;
	logic [24:0] rem_q;
	logic [57:0] nq_q;
	logic [5:0]  dcnt_q;
	logic [35:0] sn_q, sres_q, sbit_q;
	logic [4:0]  scnt_q;
	logic [16:0] rmag_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [23:0] cz_q;
	logic [4:0]  ccnt_q;
	logic        crun_q;
	hldf_pkg::hldf_item_t item_q;

	logic signed [12:0] in_dx, in_dy, in_ndx, in_ndy, dx, dy;
	logic signed [33:0] in_xs, in_ys, cxs, cys;
	logic signed [25:0] dxsq, dysq;
	logic [23:0] cross1;
	logic signed [24:0] cdiff;
	logic [25:0] dtrial;
	logic        dbit;
	logic [57:0] nq_next;
	logic [35:0] ssum, sres_next;
	logic [18:0] rinc;
	logic signed [23:0] tz;
	logic signed [16:0] tsh, tcl, theta_w;

	assign in_dx  = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
	assign in_dy  = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
	assign in_ndx = -in_dx;
	assign in_ndy = -in_dy;
	assign in_xs  = {{5{in_dy[12]}}, in_dy, 16'd0};
	assign in_ys  = {{5{in_dx[12]}}, in_dx, 16'd0};
	assign dx     = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
	assign dy     = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
	assign cxs    = cx_q >>> ccnt_q;
	assign cys    = cy_q >>> ccnt_q;
	assign dxsq   = dx * dx;
	assign dysq   = dy * dy;
	assign cross1 = y2_q * x1_q;
	assign cdiff  = $signed({1'b0, p_q}) - $signed({1'b0, cross1});
	assign dtrial = {rem_q, nq_q[57]};
	assign dbit   = dtrial >= {1'b0, l2_q};
	assign nq_next = {nq_q[56:0], dbit};
	assign ssum   = sres_q + sbit_q;
	assign sres_next = (sn_q >= ssum) ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
	assign rinc   = {1'b0, sres_next[17:0]} + 19'd1;
	assign tz     = cz_q + 24'sd64;
	assign tsh    = 17'(tz >>> 7);
	assign tcl    = (tsh > hldf_pkg::PI_Q) ? hldf_pkg::PI_Q :
		((tsh < -hldf_pkg::PI_Q) ? -hldf_pkg::PI_Q : tsh);

	always_comb begin
		if (dx == 13'sd0) begin
			theta_w = (dy < 13'sd0) ? -hldf_pkg::PI_Q : 17'sd0;
		end else if (dy == 13'sd0) begin
			theta_w = (dx > 13'sd0) ? -hldf_pkg::HALF_PI_Q : hldf_pkg::HALF_PI_Q;
		end else begin
			theta_w = -tcl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			crun_q  <= 1'b0;
		end else begin
			if (crun_q) begin
				if (cy_q >= 34'sd0) begin
					cx_q <= cx_q + cys;
					cy_q <= cy_q - cxs;
					cz_q <= cz_q + hldf_pkg::atan_entry(ccnt_q);
				end else begin
					cx_q <= cx_q - cys;
					cy_q <= cy_q + cxs;
					cz_q <= cz_q - hldf_pkg::atan_entry(ccnt_q);
				end
				ccnt_q <= ccnt_q + 5'd1;
				if (ccnt_q == 5'(hldf_pkg::CORDIC_STEPS - 1)) begin
					crun_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x1_q   <= x_start;
						y1_q   <= y_start;
						x2_q   <= x_end;
						y2_q   <= y_end;
						fin_q  <= final_segment;
						ccnt_q <= 5'd0;
						crun_q <= 1'b1;
						if (in_dy < 13'sd0) begin
							if (in_dx >= 13'sd0) begin
								cx_q <= in_ys;
								cy_q <= {{5{in_ndy[12]}}, in_ndy, 16'd0};
								cz_q <= hldf_pkg::HALF_PI_Z;
							end else begin
								cx_q <= {{5{in_ndx[12]}}, in_ndx, 16'd0};
								cy_q <= in_xs;
								cz_q <= -hldf_pkg::HALF_PI_Z;
							end
						end else begin
							cx_q <= in_xs;
							cy_q <= in_ys;
							cz_q <= 24'sd0;
						end
						state_q <= S_C0;
					end
				end
				S_C0: begin
					p_q     <= x2_q * y1_q;
					state_q <= S_C1;
				end
				S_C1: begin
					a_q     <= cdiff[24] ? 24'(-cdiff) : cdiff[23:0];
					state_q <= S_DX;
				end
				S_DX: begin
					sq_q    <= dxsq[23:0];
					state_q <= S_DY;
				end
				S_DY: begin
					l2_q    <= {1'b0, sq_q} + {1'b0, dysq[23:0]};
					state_q <= S_AA;
				end
				S_AA: begin
					if (l2_q == 25'd0) begin
						rmag_q  <= 17'd0;
						state_q <= S_FIN;
					end else begin
						nq_q    <= {48'(a_q) * 48'(a_q), 10'd0};
						rem_q   <= 25'd0;
						dcnt_q  <= 6'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= dbit ? 25'(dtrial - {1'b0, l2_q}) : dtrial[24:0];
					nq_q   <= nq_next;
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(hldf_pkg::DIV_STEPS - 1)) begin
						sn_q    <= nq_next[35:0];
						sres_q  <= 36'd0;
						sbit_q  <= 36'd1 << 34;
						scnt_q  <= 5'd0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sn_q >= ssum) begin
						sn_q <= sn_q - ssum;
					end
					sres_q <= sres_next;
					sbit_q <= sbit_q >> 2;
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'(hldf_pkg::SQRT_STEPS - 1)) begin
						rmag_q  <= rinc[17:1];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!crun_q) begin
						item_q.x_start       <= x1_q;
						item_q.y_start       <= y1_q;
						item_q.x_end         <= x2_q;
						item_q.y_end         <= y2_q;
						item_q.final_segment <= fin_q;
						item_q.theta         <= theta_w[15:0];
						item_q.rho           <= theta_w[16] ? -$signed({1'b0, rmag_q})
							: $signed({1'b0, rmag_q});
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign push = (state_q == S_PUSH) && !full;
	assign item = item_q;

endmodule

// ----- src/hldf_fifo.sv -----
// ----------------------------------------------------------------------------
// hldf_fifo
// Two-entry queue that carries converted segments from front to back.
// ----------------------------------------------------------------------------
module hldf_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hldf_pkg::hldf_item_t push_item,
	input  logic                 pop,
	output hldf_pkg::hldf_item_t head,
	output logic                 full,
	output logic                 empty
);

	hldf_pkg::hldf_item_t ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_item;
		end
	end

	assign head  = ent_q[rptr_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;

endmodule

// ----- src/hldf_back.sv -----
// ----------------------------------------------------------------------------
// hldf_back
// Stores converted segments, thins the list on its final segment and emits
// the surviving segments in list order.
// ----------------------------------------------------------------------------
module hldf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hldf_pkg::hldf_cfg_t         cfg,
	input  logic                        empty,
	input  hldf_pkg::hldf_item_t        head,
	output logic                        pop,
	output logic                        result_valid,
	output logic [hldf_pkg::COORD_W-1:0] out_x_start,
	output logic [hldf_pkg::COORD_W-1:0] out_y_start,
	output logic [hldf_pkg::COORD_W-1:0] out_x_end,
	output logic [hldf_pkg::COORD_W-1:0] out_y_end,
	output logic signed [17:0]          line_rho,
	output logic signed [15:0]          line_theta,
	output logic                        last_survivor,
	output logic                        list_overflow
);

	typedef enum logic [3:0] {
		B_IDLE, B_START, B_RDI, B_WI, B_RDJ, B_CMP, B_END, B_ECHK, B_EOUT
	} bstate_t;

	bstate_t state_q;
	logic [hldf_pkg::CNT_W-1:0]  count_q, e_q;
	logic [hldf_pkg::SEG_AW-1:0] i_q, j_q;
	logic [hldf_pkg::MAX_SEG-1:0] alive_q;
	logic ovf_q, drop_q;
	logic signed [15:0] ti_q;
	logic signed [17:0] ri_q;

	logic                          we;
	logic [hldf_pkg::SEG_AW-1:0]   addr_a;
	logic [hldf_pkg::SEG_W-1:0]    seg_rd;
	logic [hldf_pkg::POLAR_W-1:0]  pol_a, pol_b;
	logic signed [15:0] ta, tb;
	logic signed [17:0] rb;
	logic signed [16:0] dt;
	logic signed [18:0] dr;
	logic [16:0] dt_abs;
	logic [18:0] dr_abs;
	logic        dup;
	logic [hldf_pkg::CNT_W-1:0] e_inc;

	function automatic logic angle_rej(input logic signed [15:0] th,
		input logic [14:0] lim, input logic [13:0] tol);
		logic [15:0] a;
		logic signed [17:0] hi;
		a  = th[15] ? 16'(-th) : th;
		hi = 18'(hldf_pkg::PI_Q) - $signed({3'b0, lim});
		return (({1'b0, a} > {2'b0, lim}) && ($signed({2'b0, a}) < hi))
			|| ({1'b0, a} <= {3'b0, tol});
	endfunction

	assign pop    = (state_q == B_IDLE) && !empty;
	assign we     = pop && (count_q < hldf_pkg::CNT_W'(hldf_pkg::MAX_SEG));
	assign addr_a = (state_q == B_RDI) ? i_q : e_q[hldf_pkg::SEG_AW-1:0];

	hldf_ram #(.WIDTH(hldf_pkg::SEG_W), .DEPTH(hldf_pkg::MAX_SEG)) u_seg_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[hldf_pkg::SEG_AW-1:0]),
		.wdata ({head.x_start, head.y_start, head.x_end, head.y_end}),
		.raddr (e_q[hldf_pkg::SEG_AW-1:0]),
		.rdata (seg_rd)
	);

	hldf_ram #(.WIDTH(hldf_pkg::POLAR_W), .DEPTH(hldf_pkg::MAX_SEG)) u_pol_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[hldf_pkg::SEG_AW-1:0]),
		.wdata ({head.rho, head.theta}),
		.raddr (addr_a),
		.rdata (pol_a)
	);

	hldf_ram #(.WIDTH(hldf_pkg::POLAR_W), .DEPTH(hldf_pkg::MAX_SEG)) u_pol_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[hldf_pkg::SEG_AW-1:0]),
		.wdata ({head.rho, head.theta}),
		.raddr (j_q),
		.rdata (pol_b)
	);

	assign ta     = pol_a[15:0];
	assign tb     = pol_b[15:0];
	assign rb     = pol_b[33:16];
	assign dt     = 17'(ti_q) - 17'(tb);
	assign dr     = 19'(ri_q) - 19'(rb);
	assign dt_abs = dt[16] ? 17'(-dt) : dt;
	assign dr_abs = dr[18] ? 19'(-dr) : dr;
	assign dup    = (j_q != i_q) && alive_q[j_q]
		&& ((dt_abs < {2'b0, cfg.angle_similarity}) || (dr_abs < {2'b0, cfg.rho_similarity}));
	assign e_inc  = e_q + hldf_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			count_q      <= '0;
			alive_q      <= '0;
			ovf_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (we) begin
							alive_q[count_q[hldf_pkg::SEG_AW-1:0]] <= 1'b1;
							count_q <= count_q + hldf_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (head.final_segment) begin
							state_q <= B_START;
						end
					end
				end
				B_START: begin
					e_q <= '0;
					if (count_q < hldf_pkg::CNT_W'(2)) begin
						state_q <= B_ECHK;
					end else begin
						i_q     <= hldf_pkg::SEG_AW'(count_q - hldf_pkg::CNT_W'(1));
						state_q <= B_RDI;
					end
				end
				B_RDI: begin
					state_q <= B_WI;
				end
				B_WI: begin
					ti_q    <= ta;
					ri_q    <= pol_a[33:16];
					drop_q  <= angle_rej(ta, cfg.angle_limit, cfg.vertical_tolerance);
					j_q     <= '0;
					state_q <= angle_rej(ta, cfg.angle_limit, cfg.vertical_tolerance)
						? B_END : B_RDJ;
				end
				B_RDJ: begin
					state_q <= B_CMP;
				end
				B_CMP: begin
					drop_q <= dup;
					j_q    <= j_q + hldf_pkg::SEG_AW'(1);
					if (dup || ({1'b0, j_q} + hldf_pkg::CNT_W'(1) == count_q)) begin
						state_q <= B_END;
					end else begin
						state_q <= B_RDJ;
					end
				end
				B_END: begin
					if (drop_q) begin
						alive_q[i_q] <= 1'b0;
					end
					if (i_q == hldf_pkg::SEG_AW'(1)) begin
						state_q <= B_ECHK;
					end else begin
						i_q     <= i_q - hldf_pkg::SEG_AW'(1);
						state_q <= B_RDI;
					end
				end
				B_ECHK: begin
					if (e_q == count_q) begin
						alive_q <= '0;
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= B_IDLE;
					end else if (alive_q[e_q[hldf_pkg::SEG_AW-1:0]]) begin
						state_q <= B_EOUT;
					end else begin
						e_q <= e_inc;
					end
				end
				B_EOUT: begin
					result_valid  <= 1'b1;
					out_x_start   <= seg_rd[47:36];
					out_y_start   <= seg_rd[35:24];
					out_x_end     <= seg_rd[23:12];
					out_y_end     <= seg_rd[11:0];
					line_rho      <= pol_a[33:16];
					line_theta    <= ta;
					last_survivor <= (alive_q >> e_inc) == '0;
					list_overflow <= ovf_q;
					e_q           <= e_inc;
					state_q       <= B_ECHK;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/hough_line_dedup_filter_core.sv -----
// ----------------------------------------------------------------------------
// hough_line_dedup_filter_core
// Line segment list loader with polar conversion and duplicate filtering.
// ----------------------------------------------------------------------------
// A segment is taken when start is high and busy is low. With the queue not
// full, a segment of non-zero length passes through five set-up steps
// (products, magnitude and squared length), a 58-step serial divider, an
// 18-step square root, a finish step and a hand-over step back to idle, with
// the 20-step CORDIC angle unit running alongside. A zero-length segment
// skips the divider and root and is bound by the CORDIC. A two-entry queue
// lets the front take the next segment while the back unit stores or filters;
// a full queue holds the front busy. The segment flagged final_segment
// starts the filter, which compares the stored entries one at a time and
// then outputs the survivors in list order, passing over removed entries.
// Each result is shown for one cycle with result_valid; the receiver cannot
// stall, and results of a list never overlap the next.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. Reset clears the list, the queue and
// the state machines and loads the default register values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hough_line_dedup_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] x_start,
	input  logic [11:0] y_start,
	input  logic [11:0] x_end,
	input  logic [11:0] y_end,
	input  logic        final_segment,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output logic        result_valid,
	output logic [11:0] out_x_start,
	output logic [11:0] out_y_start,
	output logic [11:0] out_x_end,
	output logic [11:0] out_y_end,
	output logic signed [17:0] line_rho,
	output logic signed [15:0] line_theta,
	output logic        last_survivor,
	output logic        list_overflow
);

	hldf_pkg::hldf_cfg_t  cfg_q;
	hldf_pkg::hldf_item_t front_item, head;
	logic push, pop, full, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_limit        <= hldf_pkg::RST_ANGLE_LIMIT;
			cfg_q.angle_similarity   <= hldf_pkg::RST_ANGLE_SIM;
			cfg_q.rho_similarity     <= hldf_pkg::RST_RHO_SIM;
			cfg_q.vertical_tolerance <= hldf_pkg::RST_VERT_TOL;
		end else if (cfg_valid) begin
			case (cfg_index)
				hldf_pkg::CFG_ANGLE_LIMIT: cfg_q.angle_limit      <= cfg_data[14:0];
				hldf_pkg::CFG_ANGLE_SIM:   cfg_q.angle_similarity <= cfg_data[14:0];
				hldf_pkg::CFG_RHO_SIM:     cfg_q.rho_similarity   <= cfg_data;
				hldf_pkg::CFG_VERT_TOL:    cfg_q.vertical_tolerance <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	hldf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.x_start       (x_start),
		.y_start       (y_start),
		.x_end         (x_end),
		.y_end         (y_end),
		.final_segment (final_segment),
		.push          (push),
		.full          (full),
		.item          (front_item)
	);

	hldf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	hldf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.out_x_start   (out_x_start),
		.out_y_start   (out_y_start),
		.out_x_end     (out_x_end),
		.out_y_end     (out_y_end),
		.line_rho      (line_rho),
		.line_theta    (line_theta),
		.last_survivor (last_survivor),
		.list_overflow (list_overflow)
	);

	`ASSERT_NEXT(a_no_back_to_back, result_valid, !result_valid, "results in consecutive cycles")
	`ASSERT_NEXT(a_busy_after_take, start && !busy, busy, "front idle after a transaction")
	`ASSERT_CLK(a_no_push_when_full, !(push && full), "queue written while full")

endmodule
